// ===== rtl/core/csp_pkg.sv =====
`default_nettype none
package csp_pkg;
    localparam int SLOT_COUNT_DEF    = 16;
    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_ZERO_FC = 2'd2;

    typedef enum logic [1:0] {
        t_BK_IDLE,
        t_BK_DIV,
        t_BK_WRITE,
        t_BK_OUT
    } t_bk_state;

    // classified work item from front to back
    typedef struct packed {
        logic [7:0]  slot;
        logic [28:0] frame_id;
        logic [3:0]  dlc;
        logic [5:0]  start_bit;
        logic [6:0]  signal_size;
        logic        motorola_order;
        logic [48:0] diff;
        logic [47:0] factor;
        logic        send_now;
    } t_work;
endpackage
`default_nettype wire

// ===== rtl/core/csp_front.sv =====
`default_nettype none
module csp_front #(
    parameter int SLOT_COUNT    = csp_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BYTES = csp_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [3:0]     i_slot,
    input  wire logic [28:0]    i_frame_id,
    input  wire logic [3:0]     i_dlc,
    input  wire logic [5:0]     i_start_bit,
    input  wire logic [6:0]     i_signal_size,
    input  wire logic           i_motorola_order,
    input  wire logic [47:0]    i_phys_value,
    input  wire logic [47:0]    i_scale_offset,
    input  wire logic [47:0]    i_scale_factor,
    input  wire logic           i_send_now,
    output logic                o_q_valid,
    input  wire logic           i_q_pop,
    output csp_pkg::t_work      o_q_data
);
    // two-entry queue
    csp_pkg::t_work r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    csp_pkg::t_work n_w;
    logic push;

    always_comb begin
        // slot wrap as a constant table over the 16 input codes
        n_w.slot = '0;
        for (int k = 0; k < 16; k++) begin
            if (i_slot == 4'(k)) n_w.slot = 8'(k % SLOT_COUNT);
        end
        n_w.frame_id       = i_frame_id;
        n_w.dlc            = (i_dlc > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : i_dlc;
        n_w.start_bit      = i_start_bit;
        n_w.signal_size    = i_signal_size;
        n_w.motorola_order = i_motorola_order;
        n_w.diff           = {i_phys_value[47], i_phys_value}
                           - {i_scale_offset[47], i_scale_offset};
        n_w.factor         = i_scale_factor;
        n_w.send_now       = i_send_now;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (i_q_pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
        if (push) r_q[r_wr] <= n_w;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_rd == r_wr)) else $error("pointer mismatch");
endmodule
`default_nettype wire

// ===== rtl/core/csp_back.sv =====
`default_nettype none
module csp_back #(
    parameter int SLOT_COUNT    = csp_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BYTES = csp_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    output logic                o_q_pop,
    input  csp_pkg::t_work      i_q_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [1:0]          o_status,
    output logic                o_frame_valid,
    output logic [28:0]         o_out_frame_id,
    output logic [3:0]          o_frame_length,
    output logic [63:0]         o_payload
);
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // stores in flops (SLOT_COUNT entries, one read address)
    logic [63:0] r_pay [SLOT_COUNT];
    logic [3:0]  r_len [SLOT_COUNT];

    csp_pkg::t_bk_state r_st, n_st;
    csp_pkg::t_work r_w;
    logic [63:0] r_p;
    logic [3:0]  r_l;
    logic [1:0]  r_status;
    // bit-serial divider: num = 2|d|+|f|, den = 2|f|
    logic [50:0] r_num, n_num;
    logic [50:0] r_rem, n_rem;
    logic [5:0]  r_cnt;
    logic        r_neg;

    logic [SW-1:0] wsl;
    logic [7:0] seq_start;
    logic [48:0] ad;
    logic [47:0] af;
    logic [50:0] den;
    logic [51:0] trial;
    logic [63:0] raw;
    logic [63:0] np;

    assign wsl = i_q_data.slot[SW-1:0];
    assign seq_start = {2'b0, i_q_data.motorola_order
        ? (i_q_data.start_bit ^ 6'd7) : i_q_data.start_bit};
    assign ad  = i_q_data.diff[48] ? (49'd0 - i_q_data.diff) : i_q_data.diff;
    assign af  = i_q_data.factor[47] ? (48'd0 - i_q_data.factor) : i_q_data.factor;
    assign den = {2'b0, r_w.factor[47] ? (48'd0 - r_w.factor) : r_w.factor, 1'b0};
    assign trial = {r_rem, r_num[50]} - {1'b0, den};
    assign raw = r_neg ? (64'd0 - {13'd0, r_num}) : {13'd0, r_num};

    always_comb begin
        np = r_p;
        for (int j = 0; j < 64; j++) begin
            logic [7:0] pos;
            pos = r_w.motorola_order
                ? ((8'({2'b0, r_w.start_bit} ^ 8'd7) + 8'(r_w.signal_size) - 8'd1
                    - 8'(j)) ^ 8'd7)
                : (8'(r_w.start_bit) + 8'(j));
            if (j < 32'(r_w.signal_size)) np[pos[5:0]] = raw[j];
        end
    end

    always_comb begin
        n_st    = r_st;
        n_num   = r_num;
        n_rem   = r_rem;
        o_q_pop = 1'b0;
        case (r_st)
            csp_pkg::t_BK_IDLE: if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_st    = csp_pkg::t_BK_DIV;
                n_num   = {1'b0, ad, 1'b0} + {3'b0, af};
                n_rem   = '0;
            end
            csp_pkg::t_BK_DIV: begin
                if (r_status != csp_pkg::ST_OK) n_st = csp_pkg::t_BK_OUT;
                else begin
                    if (!trial[51]) begin
                        n_rem = trial[50:0];
                        n_num = {r_num[49:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[49:0], r_num[50]};
                        n_num = {r_num[49:0], 1'b0};
                    end
                    if (r_cnt == 6'd50) n_st = csp_pkg::t_BK_WRITE;
                end
            end
            csp_pkg::t_BK_WRITE: n_st = csp_pkg::t_BK_OUT;
            csp_pkg::t_BK_OUT: if (!o_valid || !i_stall) n_st = csp_pkg::t_BK_IDLE;
            default: n_st = csp_pkg::t_BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= csp_pkg::t_BK_IDLE;
            o_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_pay[i] <= '0;
                r_len[i] <= '0;
            end
        end else begin
            r_st  <= n_st;
            r_num <= n_num;
            r_rem <= n_rem;
            if (o_valid && !i_stall && (r_st != csp_pkg::t_BK_OUT)) o_valid <= 1'b0;
            case (r_st)
                csp_pkg::t_BK_IDLE: if (i_q_valid) begin
                    r_w   <= i_q_data;
                    r_cnt <= '0;
                    r_neg <= i_q_data.diff[48] != i_q_data.factor[47];
                    if (r_len[wsl] < i_q_data.dlc) begin
                        r_p <= '0;
                        r_l <= i_q_data.dlc;
                        r_len[wsl] <= i_q_data.dlc;
                        r_pay[wsl] <= '0;
                        r_status <= (32'(seq_start) + 32'(i_q_data.signal_size)
                            > 32'(i_q_data.dlc) * 8) ? csp_pkg::ST_RANGE
                            : (i_q_data.factor == '0) ? csp_pkg::ST_ZERO_FC : csp_pkg::ST_OK;
                    end else begin
                        r_p <= r_pay[wsl];
                        r_l <= r_len[wsl];
                        r_status <= (32'(seq_start) + 32'(i_q_data.signal_size)
                            > 32'(r_len[wsl]) * 8) ? csp_pkg::ST_RANGE
                            : (i_q_data.factor == '0) ? csp_pkg::ST_ZERO_FC : csp_pkg::ST_OK;
                    end
                end
                csp_pkg::t_BK_DIV: r_cnt <= r_cnt + 6'd1;
                csp_pkg::t_BK_WRITE: begin
                    r_p <= np;
                    r_pay[r_w.slot[SW-1:0]] <= np;
                end
                csp_pkg::t_BK_OUT: if (!o_valid || !i_stall) begin
                    o_valid        <= 1'b1;
                    o_status       <= r_status;
                    o_frame_valid  <= (r_status == csp_pkg::ST_OK) && r_w.send_now;
                    o_out_frame_id <= ((r_status == csp_pkg::ST_OK) && r_w.send_now)
                                      ? r_w.frame_id : '0;
                    o_frame_length <= r_l;
                    o_payload      <= r_p;
                end
                default: ;
            endcase
        end
    end

    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_frame_length) <= PAYLOAD_BYTES)) else $error("length");
    a_fv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_valid) |-> (o_status == csp_pkg::ST_OK)) else $error("frame");
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_st == csp_pkg::t_BK_DIV)) else $error("pop state");
endmodule
`default_nettype wire

// ===== rtl/core/can_signal_packer_unit.sv =====
// channel | valid   | stall   | beat
// in      | i_valid | o_stall | slot, frame_id, dlc, signal fields, scaling, send_now
// out     | o_valid | i_stall | status, frame_valid, out_frame_id, frame_length, payload
// one item passes through the back part in order: load, 51 restoring divider steps, pack, present
// a range or zero-factor item skips the divider steps and the pack
// front queue holds two beats so input is taken while the back part works
// synchronous active-low reset clears payload and length stores
// a stalled result is held in the output register and the back part waits behind it
`default_nettype none
module can_signal_packer_unit #(
    parameter int SLOT_COUNT    = csp_pkg::SLOT_COUNT_DEF,
    parameter int PAYLOAD_BYTES = csp_pkg::PAYLOAD_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [3:0]  i_slot,
    input  wire logic [28:0] i_frame_id,
    input  wire logic [3:0]  i_dlc,
    input  wire logic [5:0]  i_start_bit,
    input  wire logic [6:0]  i_signal_size,
    input  wire logic        i_motorola_order,
    input  wire logic [47:0] i_phys_value,
    input  wire logic [47:0] i_scale_offset,
    input  wire logic [47:0] i_scale_factor,
    input  wire logic        i_send_now,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic             o_frame_valid,
    output logic [28:0]      o_out_frame_id,
    output logic [3:0]       o_frame_length,
    output logic [63:0]      o_payload
);
    logic q_valid, q_pop;
    csp_pkg::t_work q_data;

    // front: classify and queue
    csp_front #(.SLOT_COUNT(SLOT_COUNT), .PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_slot, .i_frame_id, .i_dlc,
        .i_start_bit, .i_signal_size, .i_motorola_order, .i_phys_value,
        .i_scale_offset, .i_scale_factor, .i_send_now,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    // back: divide, pack, emit
    csp_back #(.SLOT_COUNT(SLOT_COUNT), .PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .o_valid, .i_stall, .o_status, .o_frame_valid, .o_out_frame_id,
        .o_frame_length, .o_payload
    );
endmodule
`default_nettype wire

// ===== tb/can_signal_packer_unit_tb.sv =====
`default_nettype none
module can_signal_packer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 1430;
    localparam int N_QUIET     = 150;   // tail of the run with no idling on either side
    localparam int IDLE_LIMIT  = 4000;  // cycles with no beat on either channel
    localparam int DRAIN_WAIT  = 100;

    // one input beat
    typedef struct {
        logic [3:0]         slot;
        logic [28:0]        frame_id;
        logic [3:0]         dlc;
        logic [5:0]         start_bit;
        logic [6:0]         signal_size;
        logic               motorola_order;
        logic signed [47:0] phys_value;
        logic signed [47:0] scale_offset;
        logic signed [47:0] scale_factor;
        logic               send_now;
    } sig_update_t;

    // one output beat
    typedef struct {
        logic [1:0]  status;
        logic        frame_valid;
        logic [28:0] frame_id;
        logic [3:0]  frame_length;
        logic [63:0] payload;
    } frame_result_t;

    // directed row: typed rows carry their expected beat, the rest use the packer model
    typedef struct {
        sig_update_t   upd;
        bit            typed;
        frame_result_t res;
    } directed_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_slot = '0;
    logic [28:0] i_frame_id = '0;
    logic [3:0]  i_dlc = '0;
    logic [5:0]  i_start_bit = '0;
    logic [6:0]  i_signal_size = '0;
    logic        i_motorola_order = 1'b0;
    logic [47:0] i_phys_value = '0;
    logic [47:0] i_scale_offset = '0;
    logic [47:0] i_scale_factor = '0;
    logic        i_send_now = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_frame_valid;
    logic [28:0] o_out_frame_id;
    logic [3:0]  o_frame_length;
    logic [63:0] o_payload;

    always #2 i_clk = ~i_clk;

    can_signal_packer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_slot(i_slot), .i_frame_id(i_frame_id), .i_dlc(i_dlc),
        .i_start_bit(i_start_bit), .i_signal_size(i_signal_size),
        .i_motorola_order(i_motorola_order), .i_phys_value(i_phys_value),
        .i_scale_offset(i_scale_offset), .i_scale_factor(i_scale_factor),
        .i_send_now(i_send_now),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_frame_valid(o_frame_valid),
        .o_out_frame_id(o_out_frame_id), .o_frame_length(o_frame_length),
        .o_payload(o_payload)
    );

    // model copy of the slot stores
    logic [63:0] slot_payload [16];
    logic [3:0]  slot_length [16];

    frame_result_t pending_frames[$];
    directed_row_t directed[$];
    int  error_count = 0;
    bit  quiet_tail = 1'b0;

    // round half away from zero: (2|d| + |f|) div 2|f|, sign applied last
    function automatic logic [63:0] scaled_raw(longint d, longint f);
        longint unsigned ad;
        longint unsigned af;
        longint unsigned q;
        ad = (d < 0) ? -d : d;
        af = (f < 0) ? -f : f;
        q = (2 * ad + af) / (2 * af);
        return ((d < 0) != (f < 0)) ? -q : q;
    endfunction

    // pack one signal into the model stores and return the beat it produces
    function automatic frame_result_t pack_signal(sig_update_t u);
        frame_result_t r;
        int unsigned   s;
        int unsigned   len;
        int unsigned   seq_start;
        int unsigned   pos;
        logic [63:0]   raw;
        logic [63:0]   p;
        s = u.slot;
        len = (u.dlc > 8) ? 8 : u.dlc;
        r.status = csp_pkg::ST_OK;
        r.frame_valid = 1'b0;
        // slot grows to the declared length: contents are wiped
        if (slot_length[s] < len) begin
            slot_payload[s] = '0;
            slot_length[s] = 4'(len);
        end
        // motorola start bit counted sequentially
        seq_start = u.motorola_order ? (u.start_bit ^ 7) : u.start_bit;
        if (seq_start + u.signal_size > 8 * slot_length[s]) begin
            r.status = csp_pkg::ST_RANGE;
        end else if (u.scale_factor == 0) begin
            r.status = csp_pkg::ST_ZERO_FC;
        end else begin
            raw = scaled_raw(longint'(u.phys_value) - longint'(u.scale_offset),
                             longint'(u.scale_factor));
            p = slot_payload[s];
            for (int j = 0; j < u.signal_size; j++) begin
                pos = u.motorola_order ? (((seq_start + u.signal_size - 1 - j) ^ 7) & 63)
                                       : ((u.start_bit + j) & 63);
                p[pos] = raw[j];
            end
            slot_payload[s] = p;
            r.frame_valid = u.send_now;
        end
        r.frame_id = r.frame_valid ? u.frame_id : '0;
        r.frame_length = slot_length[s];
        r.payload = slot_payload[s];
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // mostly well-placed signals with random content, some pure noise
    function automatic sig_update_t rand_update();
        sig_update_t u;
        int unsigned bits;
        int unsigned first;
        u.slot = 4'($urandom_range(0, 15));
        u.frame_id = 29'($urandom());
        u.send_now = 1'($urandom_range(0, 1));
        u.motorola_order = 1'($urandom_range(0, 1));
        u.phys_value = rand48();
        u.scale_offset = rand48();
        if ($urandom_range(0, 9) < 8) begin
            u.dlc = 4'($urandom_range(1, 8));
            bits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8 * u.dlc)
                                               : $urandom_range(1, (u.dlc > 2) ? 16 : 8 * u.dlc);
            first = $urandom_range(0, 8 * u.dlc - bits);
            u.signal_size = 7'(bits);
            u.start_bit = 6'(u.motorola_order ? (first ^ 7) : first);
            u.scale_factor = 48'($urandom_range(1, 1 << 20));
            if ($urandom_range(0, 1))
                u.scale_factor = -u.scale_factor;
            // sometimes a full-width random scale factor
            if ($urandom_range(0, 3) == 0)
                u.scale_factor = rand48();
        end else begin
            u.dlc = 4'($urandom());
            u.start_bit = 6'($urandom());
            u.signal_size = 7'($urandom());
            u.scale_factor = ($urandom_range(0, 2) == 0) ? '0 : rand48();
        end
        return u;
    endfunction

    function automatic sig_update_t mk(int slot, int fid, int dlc, int sb, int sz, bit moto,
                                       longint v, longint o, longint f, bit send);
        sig_update_t u;
        u.slot = 4'(slot); u.frame_id = 29'(fid); u.dlc = 4'(dlc); u.start_bit = 6'(sb);
        u.signal_size = 7'(sz); u.motorola_order = moto; u.phys_value = 48'(v);
        u.scale_offset = 48'(o); u.scale_factor = 48'(f); u.send_now = send;
        return u;
    endfunction

    function automatic frame_result_t fr(logic [1:0] st, bit fv, int fid, int len,
                                         logic [63:0] p);
        frame_result_t r;
        r.status = st; r.frame_valid = fv; r.frame_id = 29'(fid);
        r.frame_length = 4'(len); r.payload = p;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(sig_update_t u, bit typed, frame_result_t res);
        directed_row_t row;
        row.upd = u;
        row.typed = typed;
        row.res = res;
        directed.insert(directed.size(), row);
    endfunction

    // drive one beat, hold it through stalls, predict at acceptance
    task automatic send_update(sig_update_t u, bit typed, frame_result_t typed_res);
        frame_result_t r;
        i_valid <= 1'b1;
        i_slot <= u.slot;
        i_frame_id <= u.frame_id;
        i_dlc <= u.dlc;
        i_start_bit <= u.start_bit;
        i_signal_size <= u.signal_size;
        i_motorola_order <= u.motorola_order;
        i_phys_value <= u.phys_value;
        i_scale_offset <= u.scale_offset;
        i_scale_factor <= u.scale_factor;
        i_send_now <= u.send_now;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        r = pack_signal(u);
        if (typed)
            r = typed_res;
        pending_frames.insert(pending_frames.size(), r);
        // random idle burst before the next beat
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    localparam longint ONE = 64'sh10000;   // 1.0 in Q31.16
    localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
    localparam longint MIN48 = -64'sh8000_0000_0000;

    initial begin
        frame_result_t none;
        none = fr(csp_pkg::ST_OK, 0, 0, 0, '0);
        for (int k = 0; k < 16; k++) begin
            slot_payload[k] = '0;
            slot_length[k] = '0;
        end
        // fresh slots: results are readable straight off the inputs
        add_row(mk(0, 'h123, 8, 0, 8, 0, 5 * ONE, 0, ONE, 1), 1,
                fr(csp_pkg::ST_OK, 1, 'h123, 8, 64'h5));
        add_row(mk(1, 'h55, 4, 0, 8, 0, ONE, 0, 0, 1), 1,
                fr(csp_pkg::ST_ZERO_FC, 0, 0, 4, '0));
        add_row(mk(2, 'h66, 1, 4, 8, 0, ONE, 0, ONE, 1), 1,
                fr(csp_pkg::ST_RANGE, 0, 0, 1, '0));
        add_row(mk(3, 'h1FFF_FFFF, 15, 0, 8, 0, 7 * ONE, 0, ONE, 1), 1,
                fr(csp_pkg::ST_OK, 1, 'h1FFF_FFFF, 8, 64'h7));
        add_row(mk(4, 'h77, 0, 0, 0, 0, ONE, 0, ONE, 1), 1,
                fr(csp_pkg::ST_OK, 1, 'h77, 0, '0));
        // extremes and orderings, checked by the packer model
        add_row(mk(5, 1, 8, 0, 64, 0, MAX48, MIN48, 1, 1), 0, none);
        add_row(mk(5, 2, 8, 7, 64, 1, MIN48, MAX48, 1, 1), 0, none);
        add_row(mk(6, 3, 8, 63, 1, 1, ONE, 0, ONE, 0), 0, none);
        add_row(mk(6, 4, 8, 7, 12, 1, 'hABC * ONE, 0, ONE, 1), 0, none);
        add_row(mk(6, 5, 8, 60, 4, 0, -ONE, 0, ONE, 1), 0, none);
        add_row(mk(7, 6, 2, 3, 0, 1, ONE, 0, ONE, 1), 0, none);
        add_row(mk(7, 7, 2, 0, 127, 0, ONE, 0, ONE, 1), 0, none);
        add_row(mk(7, 8, 2, 15, 2, 1, ONE, 0, ONE, 1), 0, none);
        // halves round away from zero
        add_row(mk(8, 9, 2, 0, 8, 0, 3 * ONE, 0, 2 * ONE, 1), 0, none);
        add_row(mk(8, 10, 2, 8, 8, 0, -3 * ONE, 0, 2 * ONE, 1), 0, none);
        add_row(mk(8, 11, 2, 0, 8, 0, 3 * ONE, 0, -2 * ONE, 1), 0, none);
        add_row(mk(8, 12, 2, 8, 8, 0, 5 * ONE, ONE, -ONE, 1), 0, none);
        // shorter dlc keeps the stored length and bits
        add_row(mk(8, 13, 1, 12, 4, 0, 9 * ONE, 0, ONE, 1), 0, none);
        add_row(mk(15, 14, 9, 56, 8, 0, 'hFF * ONE, 0, ONE, 1), 0, none);
        add_row(mk(15, 15, 8, 0, 8, 0, ONE, 0, 0, 1), 0, none);
        add_row(mk(15, 16, 8, 59, 8, 1, 'h3C * ONE, 0, ONE, 1), 0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_update(directed[k].upd, directed[k].typed, directed[k].res);

        for (int k = 0; k < N_RANDOM; k++) begin
            // let the block drain completely once mid-run
            if (k == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                wait (pending_frames.size() == 0);
                @(posedge i_clk);
            end
            if (k == N_RANDOM - N_QUIET)
                quiet_tail = 1'b1;
            send_update(rand_update(), 0, none);
        end
        i_valid <= 1'b0;

        wait (pending_frames.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0 && pending_frames.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: stall bursts and result checking
    int stall_left = 0;
    always @(posedge i_clk) begin
        frame_result_t e;
        if (o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result beat, payload %h", $time, o_payload);
                error_count++;
            end else begin
                e = pending_frames.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, o_status);
                    error_count++;
                end
                if (o_frame_valid !== e.frame_valid) begin
                    $display("%0t: frame_valid exp %0d got %0d", $time, e.frame_valid,
                             o_frame_valid);
                    error_count++;
                end
                if (o_out_frame_id !== e.frame_id) begin
                    $display("%0t: frame_id exp %h got %h", $time, e.frame_id,
                             o_out_frame_id);
                    error_count++;
                end
                if (o_frame_length !== e.frame_length) begin
                    $display("%0t: frame_length exp %0d got %0d", $time, e.frame_length,
                             o_frame_length);
                    error_count++;
                end
                if (o_payload !== e.payload) begin
                    $display("%0t: payload exp %h got %h", $time, e.payload, o_payload);
                    error_count++;
                end
            end
        end
        // stall comes in bursts, none in the quiet tail
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet_tail && i_rst_n && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no beat on either channel
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still due", $time, pending_frames.size());
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/csp_pkg.sv
rtl/core/csp_front.sv
rtl/core/csp_back.sv
rtl/core/can_signal_packer_unit.sv
tb/can_signal_packer_unit_tb.sv
